FILE: hdl/sac_pkg.sv
package sac_pkg;

    // Fixed field widths
    localparam int VEL_BITS  = 16;
    localparam int FT_BITS   = 10;
    localparam int DV_BITS   = 17;   // velocity difference
    localparam int DISP_BITS = 28;   // (va - vb) * frame_time, Q20.8
    localparam int MAG_BITS  = 26;   // |displacement| never reaches 2^26
    localparam int PX_BITS   = 20;   // displacement in whole pixels
    localparam int OUT_T_BITS = 16;  // entry_time port width

    localparam logic [FT_BITS-1:0] FT_RESET = 10'd16;

    // Hit side codes
    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_TOP    = 2'd3;

    // Three-way compare result
    typedef enum logic [1:0] {
        CMP_LT,
        CMP_EQ,
        CMP_GT
    } t_cmp;

    // Infinity tag of a time value; encoding order matches numeric order
    typedef enum logic [1:0] {
        INF_NEG,
        INF_NONE,
        INF_POS
    } t_inf;

    // Control that travels alongside the divider payload
    typedef struct packed {
        logic       valid;
        logic       hit;
        logic [1:0] side;
    } t_ctl;

    // Compare two times given their infinity tags and the cross-product compare
    function automatic t_cmp time_cmp(t_inf a, t_inf b, logic lt, logic eq);
        t_cmp res;
        if (a != INF_NONE || b != INF_NONE) begin
            if (a == b) res = CMP_EQ;
            else if (a < b) res = CMP_LT;
            else res = CMP_GT;
        end else if (lt) begin
            res = CMP_LT;
        end else if (eq) begin
            res = CMP_EQ;
        end else begin
            res = CMP_GT;
        end
        return res;
    endfunction

endpackage

FILE: hdl/sac_div_cell.sv
// One restoring-division cell: produces one quotient bit per item.
module sac_div_cell #(
    parameter int D_BITS = 26,
    parameter int Q_BITS = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  sac_pkg::t_ctl       i_ctl,
    input  logic [D_BITS-1:0]   i_rem,
    input  logic [D_BITS-1:0]   i_den,
    input  logic [Q_BITS-1:0]   i_quo,
    output sac_pkg::t_ctl       o_ctl,
    output logic [D_BITS-1:0]   o_rem,
    output logic [D_BITS-1:0]   o_den,
    output logic [Q_BITS-1:0]   o_quo
);

    logic [D_BITS:0]   w_trial;
    logic              w_ge;
    logic [D_BITS:0]   w_diff;
    sac_pkg::t_ctl     r_ctl;
    logic [D_BITS-1:0] r_rem, n_rem;
    logic [D_BITS-1:0] r_den;
    logic [Q_BITS-1:0] r_quo, n_quo;

    // Shift remainder, trial subtract; remainder stays below the divisor
    always_comb begin
        w_trial = {i_rem, 1'b0};
        w_ge    = w_trial >= {1'b0, i_den};
        w_diff  = w_trial - {1'b0, i_den};
        n_rem   = w_ge ? w_diff[D_BITS-1:0] : w_trial[D_BITS-1:0];
        n_quo   = {i_quo[Q_BITS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

FILE: hdl/sac_front.sv
// Geometry and time-compare pipeline: seven stages from box pair to
// hit decision plus divider operands.
module sac_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [sac_pkg::FT_BITS-1:0]   i_frame_time,
    input  logic signed [COORD_BITS-1:0]  i_a_left,
    input  logic signed [COORD_BITS-1:0]  i_a_right,
    input  logic signed [COORD_BITS-1:0]  i_a_bottom,
    input  logic signed [COORD_BITS-1:0]  i_a_top,
    input  logic signed [COORD_BITS-1:0]  i_b_left,
    input  logic signed [COORD_BITS-1:0]  i_b_right,
    input  logic signed [COORD_BITS-1:0]  i_b_bottom,
    input  logic signed [COORD_BITS-1:0]  i_b_top,
    input  logic signed [sac_pkg::VEL_BITS-1:0] i_a_vel_x,
    input  logic signed [sac_pkg::VEL_BITS-1:0] i_a_vel_y,
    input  logic signed [sac_pkg::VEL_BITS-1:0] i_b_vel_x,
    input  logic signed [sac_pkg::VEL_BITS-1:0] i_b_vel_y,
    output sac_pkg::t_ctl                 o_ctl,
    output logic [sac_pkg::MAG_BITS-1:0]  o_rem,
    output logic [sac_pkg::MAG_BITS-1:0]  o_den
);

    localparam int C_BITS = COORD_BITS;
    localparam int N_BITS = C_BITS + 1;
    localparam int M_BITS = sac_pkg::MAG_BITS;
    localparam int D_BITS = sac_pkg::DISP_BITS;
    localparam int P_BITS = N_BITS + M_BITS + 1;
    localparam int G_BITS = ((C_BITS > sac_pkg::PX_BITS) ? C_BITS : sac_pkg::PX_BITS) + 1;
    localparam int A_BITS = ((N_BITS + 9) > (M_BITS + 2)) ? (N_BITS + 9) : (M_BITS + 2);

    typedef struct packed {
        sac_pkg::t_inf     inf;
        logic [N_BITS-1:0] n;
        logic [M_BITS-1:0] d;
    } t_time;

    typedef struct packed {
        logic signed [C_BITS-1:0] al, ar, ab, at, bl, br, bb, bt;
    } t_box;

    // Entry/exit times of one axis
    function automatic t_time axis_en(logic signed [D_BITS-1:0] disp,
                                      logic signed [C_BITS-1:0] lo_a,
                                      logic signed [C_BITS-1:0] hi_a,
                                      logic signed [C_BITS-1:0] lo_b,
                                      logic signed [C_BITS-1:0] hi_b,
                                      logic is_exit);
        t_time                    t;
        logic signed [N_BITS-1:0] num;
        logic signed [D_BITS-1:0] mag;
        if (!disp[D_BITS-1]) begin
            num = is_exit ? (N_BITS'(hi_b) - N_BITS'(lo_a)) : (N_BITS'(lo_b) - N_BITS'(hi_a));
            mag = disp;
        end else begin
            num = is_exit ? (N_BITS'(hi_a) - N_BITS'(lo_b)) : (N_BITS'(lo_a) - N_BITS'(hi_b));
            mag = -disp;
        end
        if (disp == '0) begin
            t.inf = is_exit ? sac_pkg::INF_POS : sac_pkg::INF_NEG;
            t.n   = '0;
            t.d   = M_BITS'(1);
        end else begin
            t.inf = sac_pkg::INF_NONE;
            t.n   = num;
            t.d   = mag[M_BITS-1:0];
        end
        return t;
    endfunction

    function automatic logic below_zero(t_time t);
        return (t.inf == sac_pkg::INF_NEG) || (t.inf == sac_pkg::INF_NONE && t.n[N_BITS-1]);
    endfunction

    function automatic logic above_one(t_time t);
        logic signed [A_BITS-1:0] sn;
        logic signed [A_BITS-1:0] sd;
        sn = A_BITS'($signed(t.n)) <<< 8;
        sd = A_BITS'($signed({1'b0, t.d}));
        return (t.inf == sac_pkg::INF_POS) || (t.inf == sac_pkg::INF_NONE && sn > sd);
    endfunction

    function automatic logic signed [P_BITS-1:0] xprod(t_time a, t_time b);
        return P_BITS'($signed(a.n)) * P_BITS'($signed({1'b0, b.d}));
    endfunction

    // Stage 1: capture item, velocity differences
    logic                            r1_valid;
    t_box                            r1_box, n1_box;
    logic signed [sac_pkg::DV_BITS-1:0] r1_dvx, r1_dvy, n1_dvx, n1_dvy;
    logic [sac_pkg::FT_BITS-1:0]     r1_ft;

    always_comb begin
        n1_box = '{i_a_left, i_a_right, i_a_bottom, i_a_top,
                   i_b_left, i_b_right, i_b_bottom, i_b_top};
        n1_dvx = sac_pkg::DV_BITS'(i_a_vel_x) - sac_pkg::DV_BITS'(i_b_vel_x);
        n1_dvy = sac_pkg::DV_BITS'(i_a_vel_y) - sac_pkg::DV_BITS'(i_b_vel_y);
    end

    // Stage 2: displacement
    logic                     r2_valid;
    t_box                     r2_box;
    logic signed [D_BITS-1:0] r2_dx, r2_dy, n2_dx, n2_dy;

    always_comb begin
        n2_dx = D_BITS'(r1_dvx) * D_BITS'($signed({1'b0, r1_ft}));
        n2_dy = D_BITS'(r1_dvy) * D_BITS'($signed({1'b0, r1_ft}));
    end

    // Stage 3: whole-pixel displacement (toward zero) and axis times
    logic                                 r3_valid;
    t_box                                 r3_box;
    logic signed [sac_pkg::PX_BITS-1:0]   r3_px, r3_py, n3_px, n3_py;
    logic signed [D_BITS-1:0]             w3_bx, w3_by;
    t_time                                r3_enx, r3_exx, r3_eny, r3_exy;
    t_time                                n3_enx, n3_exx, n3_eny, n3_exy;
    logic                                 r3_xneg, r3_yneg;

    always_comb begin
        w3_bx  = $signed({{(D_BITS-8){1'b0}}, {8{r2_dx[D_BITS-1]}}});
        w3_by  = $signed({{(D_BITS-8){1'b0}}, {8{r2_dy[D_BITS-1]}}});
        n3_px  = sac_pkg::PX_BITS'((r2_dx + w3_bx) >>> 8);
        n3_py  = sac_pkg::PX_BITS'((r2_dy + w3_by) >>> 8);
        n3_enx = axis_en(r2_dx, r2_box.al, r2_box.ar, r2_box.bl, r2_box.br, 1'b0);
        n3_exx = axis_en(r2_dx, r2_box.al, r2_box.ar, r2_box.bl, r2_box.br, 1'b1);
        n3_eny = axis_en(r2_dy, r2_box.ab, r2_box.at, r2_box.bb, r2_box.bt, 1'b0);
        n3_exy = axis_en(r2_dy, r2_box.ab, r2_box.at, r2_box.bb, r2_box.bt, 1'b1);
    end

    // Stage 4: broad-phase overlap and cross products
    logic                     r4_valid, r4_ovl, n4_ovl;
    t_time                    r4_enx, r4_exx, r4_eny, r4_exy;
    logic                     r4_xneg, r4_yneg;
    logic signed [P_BITS-1:0] r4_enl, r4_enr, r4_exl, r4_exr;
    logic signed [G_BITS-1:0] w4_gl, w4_gr, w4_gb, w4_gt;

    always_comb begin
        w4_gl = G_BITS'(r3_box.al);
        w4_gr = G_BITS'(r3_box.ar);
        w4_gb = G_BITS'(r3_box.ab);
        w4_gt = G_BITS'(r3_box.at);
        if (!r3_px[sac_pkg::PX_BITS-1]) w4_gr = G_BITS'(r3_box.ar) + G_BITS'(r3_px);
        else w4_gl = G_BITS'(r3_box.al) + G_BITS'(r3_px);
        if (!r3_py[sac_pkg::PX_BITS-1]) w4_gt = G_BITS'(r3_box.at) + G_BITS'(r3_py);
        else w4_gb = G_BITS'(r3_box.ab) + G_BITS'(r3_py);
        n4_ovl = !(G_BITS'(r3_box.br) < w4_gl || G_BITS'(r3_box.bl) > w4_gr ||
                   G_BITS'(r3_box.bt) < w4_gb || G_BITS'(r3_box.bb) > w4_gt);
    end

    // Stage 5: latest entry, earliest exit, window checks, side
    logic          r5_valid, r5_ok, n5_ok;
    t_time         r5_ent, r5_ext, n5_ent, n5_ext;
    logic [1:0]    r5_side, n5_side;
    sac_pkg::t_cmp w5_cen, w5_cex;

    always_comb begin
        w5_cen = sac_pkg::time_cmp(r4_enx.inf, r4_eny.inf, r4_enl < r4_enr, r4_enl == r4_enr);
        w5_cex = sac_pkg::time_cmp(r4_exx.inf, r4_exy.inf, r4_exl < r4_exr, r4_exl == r4_exr);
        n5_ent = (w5_cen != sac_pkg::CMP_LT) ? r4_enx : r4_eny;
        n5_ext = (w5_cex != sac_pkg::CMP_GT) ? r4_exx : r4_exy;
        n5_ok  = r4_ovl && !(below_zero(r4_enx) && below_zero(r4_eny)) &&
                 !above_one(r4_enx) && !above_one(r4_eny);
        if (w5_cen != sac_pkg::CMP_LT) n5_side = r4_xneg ? sac_pkg::SIDE_LEFT : sac_pkg::SIDE_RIGHT;
        else n5_side = r4_yneg ? sac_pkg::SIDE_BOTTOM : sac_pkg::SIDE_TOP;
    end

    // Stage 6: entry-versus-exit cross products
    logic                     r6_valid, r6_ok;
    t_time                    r6_ent, r6_ext;
    logic [1:0]               r6_side;
    logic signed [P_BITS-1:0] r6_l, r6_r;

    // Stage 7: hit decision and divider operands
    sac_pkg::t_ctl     r7_ctl, n7_ctl;
    logic [M_BITS-1:0] r7_rem, n7_rem, r7_den, n7_den;
    sac_pkg::t_cmp     w7_cmp;

    always_comb begin
        w7_cmp       = sac_pkg::time_cmp(r6_ent.inf, r6_ext.inf, r6_l < r6_r, r6_l == r6_r);
        n7_ctl.valid = r6_valid;
        n7_ctl.hit   = r6_ok && (w7_cmp != sac_pkg::CMP_GT);
        n7_ctl.side  = n7_ctl.hit ? r6_side : sac_pkg::SIDE_LEFT;
        // entry numerator scaled so the first cell's shift makes it n*256
        n7_rem       = n7_ctl.hit ? (M_BITS'(r6_ent.n) << 7) : '0;
        n7_den       = n7_ctl.hit ? r6_ent.d : M_BITS'(1);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_ctl   <= '0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_ctl   <= n7_ctl;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_box  <= n1_box;
            r1_dvx  <= n1_dvx;
            r1_dvy  <= n1_dvy;
            r1_ft   <= i_frame_time;
            r2_box  <= r1_box;
            r2_dx   <= n2_dx;
            r2_dy   <= n2_dy;
            r3_box  <= r2_box;
            r3_px   <= n3_px;
            r3_py   <= n3_py;
            r3_enx  <= n3_enx;
            r3_exx  <= n3_exx;
            r3_eny  <= n3_eny;
            r3_exy  <= n3_exy;
            r3_xneg <= r2_dx[D_BITS-1];
            r3_yneg <= r2_dy[D_BITS-1];
            r4_ovl  <= n4_ovl;
            r4_enx  <= r3_enx;
            r4_exx  <= r3_exx;
            r4_eny  <= r3_eny;
            r4_exy  <= r3_exy;
            r4_xneg <= r3_xneg;
            r4_yneg <= r3_yneg;
            r4_enl  <= xprod(r3_enx, r3_eny);
            r4_enr  <= xprod(r3_eny, r3_enx);
            r4_exl  <= xprod(r3_exx, r3_exy);
            r4_exr  <= xprod(r3_exy, r3_exx);
            r5_ok   <= n5_ok;
            r5_ent  <= n5_ent;
            r5_ext  <= n5_ext;
            r5_side <= n5_side;
            r6_ok   <= r5_ok;
            r6_ent  <= r5_ent;
            r6_ext  <= r5_ext;
            r6_side <= r5_side;
            r6_l    <= xprod(r5_ent, r5_ext);
            r6_r    <= xprod(r5_ext, r5_ent);
            r7_rem  <= n7_rem;
            r7_den  <= n7_den;
        end
    end

    assign o_ctl = r7_ctl;
    assign o_rem = r7_rem;
    assign o_den = r7_den;

endmodule

FILE: hdl/swept_aabb_collision.sv
// Swept box collision test: each beat carries two boxes and their velocities
// and returns hit, entry time (Q2.14, 2.0 on a miss) and hit side. The block
// takes one box pair per clock while not stalled and delivers one result per
// pair, in order. Each pair passes through seven geometry and compare stages,
// a chain of TIME_FRAC_BITS + 1 divider cells (one entry-time bit each),
// and the output register. A skid register behind the output lets one
// more result land while the output is stalled; input stall rises only
// once that skid register is occupied. frame_time may be written at any
// cycle (always ready) but must only change while no pairs are in flight.
module swept_aabb_collision #(
    parameter int COORD_BITS     = 16,
    parameter int TIME_FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_BITS-1:0]  i_a_left,
    input  logic signed [COORD_BITS-1:0]  i_a_right,
    input  logic signed [COORD_BITS-1:0]  i_a_bottom,
    input  logic signed [COORD_BITS-1:0]  i_a_top,
    input  logic signed [COORD_BITS-1:0]  i_b_left,
    input  logic signed [COORD_BITS-1:0]  i_b_right,
    input  logic signed [COORD_BITS-1:0]  i_b_bottom,
    input  logic signed [COORD_BITS-1:0]  i_b_top,
    input  logic signed [sac_pkg::VEL_BITS-1:0] i_a_vel_x,
    input  logic signed [sac_pkg::VEL_BITS-1:0] i_a_vel_y,
    input  logic signed [sac_pkg::VEL_BITS-1:0] i_b_vel_x,
    input  logic signed [sac_pkg::VEL_BITS-1:0] i_b_vel_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [sac_pkg::OUT_T_BITS-1:0] o_entry_time,
    output logic [1:0]                    o_hit_side,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sac_pkg::FT_BITS-1:0]   i_cfg_frame_time
);

    localparam int Q_BITS = TIME_FRAC_BITS + 1;
    localparam int M_BITS = sac_pkg::MAG_BITS;
    localparam logic [sac_pkg::OUT_T_BITS-1:0] MISS_TIME =
        sac_pkg::OUT_T_BITS'(32'd2 << TIME_FRAC_BITS);
    localparam logic [Q_BITS-1:0] Q_ONE = {1'b1, {TIME_FRAC_BITS{1'b0}}};

    logic                        w_en;
    logic [sac_pkg::FT_BITS-1:0] r_frame_time;

    // Config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time <= sac_pkg::FT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frame_time <= i_cfg_frame_time;
        end
    end

    // Divider chain links
    sac_pkg::t_ctl     w_ctl [Q_BITS+1];
    logic [M_BITS-1:0] w_rem [Q_BITS+1];
    logic [M_BITS-1:0] w_den [Q_BITS+1];
    logic [Q_BITS-1:0] w_quo [Q_BITS+1];

    sac_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_in_valid && !o_in_stall),
        .i_frame_time (r_frame_time),
        .i_a_left     (i_a_left),
        .i_a_right    (i_a_right),
        .i_a_bottom   (i_a_bottom),
        .i_a_top      (i_a_top),
        .i_b_left     (i_b_left),
        .i_b_right    (i_b_right),
        .i_b_bottom   (i_b_bottom),
        .i_b_top      (i_b_top),
        .i_a_vel_x    (i_a_vel_x),
        .i_a_vel_y    (i_a_vel_y),
        .i_b_vel_x    (i_b_vel_x),
        .i_b_vel_y    (i_b_vel_y),
        .o_ctl        (w_ctl[0]),
        .o_rem        (w_rem[0]),
        .o_den        (w_den[0])
    );

    assign w_quo[0] = '0;

    for (genvar g = 0; g < Q_BITS; g++) begin : g_cell
        sac_div_cell #(
            .D_BITS (M_BITS),
            .Q_BITS (Q_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_rem   (w_rem[g]),
            .i_den   (w_den[g]),
            .i_quo   (w_quo[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_den   (w_den[g+1]),
            .o_quo   (w_quo[g+1])
        );
    end

    // Output register with skid
    logic                               r_out_valid, n_out_valid;
    logic                               r_skid_valid, n_skid_valid;
    logic                               r_out_hit, r_skid_hit;
    logic [sac_pkg::OUT_T_BITS-1:0]     r_out_time, r_skid_time;
    logic [1:0]                         r_out_side, r_skid_side;
    logic                               w_pipe_valid, w_take;
    logic                               w_load_skid2out, w_load_pipe2out, w_load_skid;
    logic [sac_pkg::OUT_T_BITS-1:0]     w_pipe_time;

    assign w_en         = !r_skid_valid;
    assign o_in_stall   = r_skid_valid;
    assign w_pipe_valid = w_ctl[Q_BITS].valid && w_en;
    assign w_take       = r_out_valid && !i_out_stall;
    assign w_pipe_time  = w_ctl[Q_BITS].hit ?
                          sac_pkg::OUT_T_BITS'(w_quo[Q_BITS]) : MISS_TIME;

    always_comb begin
        n_out_valid     = r_out_valid;
        n_skid_valid    = r_skid_valid;
        w_load_skid2out = 1'b0;
        w_load_pipe2out = 1'b0;
        w_load_skid     = 1'b0;
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                w_load_skid2out = 1'b1;
                n_skid_valid    = 1'b0;
                n_out_valid     = 1'b1;
            end else if (w_pipe_valid) begin
                w_load_pipe2out = 1'b1;
                n_out_valid     = 1'b1;
            end else begin
                n_out_valid     = 1'b0;
            end
        end else if (w_pipe_valid) begin
            w_load_skid  = 1'b1;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_skid2out) begin
            r_out_hit  <= r_skid_hit;
            r_out_time <= r_skid_time;
            r_out_side <= r_skid_side;
        end else if (w_load_pipe2out) begin
            r_out_hit  <= w_ctl[Q_BITS].hit;
            r_out_time <= w_pipe_time;
            r_out_side <= w_ctl[Q_BITS].side;
        end
        if (w_load_skid) begin
            r_skid_hit  <= w_ctl[Q_BITS].hit;
            r_skid_time <= w_pipe_time;
            r_skid_side <= w_ctl[Q_BITS].side;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_entry_time = r_out_time;
    assign o_hit_side   = r_out_side;

    // Skid only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output is empty");

    // A drained output refills from the skid on the next edge
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_out_stall |=> r_out_valid && !r_skid_valid)
        else $error("skid beat not moved to output");

    // Hit entry time never exceeds 1.0
    a_entry_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[Q_BITS].valid && w_ctl[Q_BITS].hit |-> w_quo[Q_BITS] <= Q_ONE)
        else $error("entry time beyond frame on a hit");

endmodule
